[src/fst_pkg.sv]
// ----------------------------------------------------------------------------
// fst_pkg
// Shared types, constants and hash functions for the flow session table.
// ----------------------------------------------------------------------------
`default_nettype none
package fst_pkg;
   localparam int Buckets = 1024;
   localparam int Ways = 4;
   localparam int Slots = Buckets * Ways;
   localparam int BucketW = $clog2(Buckets);
   localparam int WayW = (Ways > 1) ? $clog2(Ways) : 1;
   localparam int SlotW = $clog2(Slots);
   localparam int WayFieldW = $clog2(Ways);

   localparam logic [1:0] OP_GET = 2'd0;
   localparam logic [1:0] OP_FIND = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   localparam logic [7:0] PROTO_TCP = 8'd6;
   localparam logic [7:0] PROTO_UDP = 8'd17;
   localparam logic [7:0] PROTO_ICMP = 8'd1;

   localparam logic [1:0] REG_TCP = 2'd0;
   localparam logic [1:0] REG_UDP = 2'd1;
   localparam logic [1:0] REG_ICMP = 2'd2;

   // One stored session: valid, tuple, proto/bound, last seen, TCP marks
   typedef struct packed {
      logic        valid;
      logic [31:0] src_addr;
      logic [31:0] dst_addr;
      logic [31:0] ports;
      logic [9:0]  proto_bound;
      logic [31:0] last_seen;
      logic [3:0]  marks;
   } entry_type;

   // Symmetric bucket hash, first half (xor fold), registered before the multiply
   function automatic logic [31:0] hash_fold(input logic [31:0] a, input logic [15:0] ap,
                                             input logic [31:0] b, input logic [15:0] bp,
                                             input logic [7:0] proto, input logic [1:0] bound);
      logic [31:0] h;
      h = ((a ^ {16'd0, ap}) ^ (b ^ {16'd0, bp})) + {24'd0, proto} + {30'd0, bound};
      h = h ^ (h >> 16);
      h = h ^ (h >> 8);
      return h;
   endfunction

   function automatic logic [BucketW-1:0] hash_mix(input logic [31:0] h);
      logic [31:0] m;
      m = 32'h9e37 * {16'd0, h[15:0]} + 32'h5365 * {16'd0, h[31:16]};
      return m[BucketW-1:0];
   endfunction
endpackage
`default_nettype wire

[src/flow_session_table.sv]
// ----------------------------------------------------------------------------
// flow_session_table
// Firewall connection table: bucketed session memory with per-packet
// lookup, create, TCP tracking and a once-per-second timeout sweep.
// ----------------------------------------------------------------------------
// Sequence: a find or get hashes the tuple, then reads and compares the bucket's ways
// in order until a hit; a search repeats the lookup for up to three bound kinds.
// A get that sweeps first reads and checks every entry before its lookup.
// Throughput: one item at a time; busy stays high until the result strobe, since
// the single memory port allows one read or write a cycle.
// Reset: a clearing pass over every slot follows reset; busy is high meanwhile.
`default_nettype none
module flow_session_table (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [1:0]  req_operation,
   input  wire logic [31:0] req_src_addr,
   input  wire logic [15:0] req_src_port_num,
   input  wire logic [31:0] req_dst_addr,
   input  wire logic [15:0] req_dst_port_num,
   input  wire logic [7:0]  req_proto,
   input  wire logic [1:0]  req_bound_kind,
   input  wire logic [7:0]  req_tcp_flags,
   input  wire logic [31:0] req_now_seconds,
   output      logic        rsp_valid,
   output      logic        rsp_hit,
   output      logic        rsp_created,
   output      logic        rsp_from_destination,
   output      logic [11:0] rsp_session_slot,
   output      logic        rsp_closed,
   output      logic        rsp_table_full,
   output      logic [12:0] rsp_expired_count,
   output      logic [12:0] rsp_active_sessions,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [3:0]  paddr,
   input  wire logic [31:0] pwdata,
   output      logic [31:0] prdata,
   output      logic        pready
);
   localparam int SlotW = fst_pkg::SlotW;
   localparam int BucketW = fst_pkg::BucketW;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_SWEEP_RD, ST_SWEEP_CHK, ST_HASH, ST_MIX,
      ST_RD, ST_CMP, ST_DECIDE, ST_WRITE, ST_DONE
   } state_type;

   // Configuration registers
   logic [15:0] tcp_to_ff, udp_to_ff, icmp_to_ff;
   logic        cfg_wr;
   assign pready = 1'b1;
   assign cfg_wr = psel & penable & pwrite;
   always_ff @(posedge clock) begin
      if (reset) begin
         tcp_to_ff <= 16'd3600;
         udp_to_ff <= 16'd60;
         icmp_to_ff <= 16'd30;
      end else if (cfg_wr) begin
         case (paddr[3:2])
            fst_pkg::REG_TCP:  tcp_to_ff <= pwdata[15:0];
            fst_pkg::REG_UDP:  udp_to_ff <= pwdata[15:0];
            fst_pkg::REG_ICMP: icmp_to_ff <= pwdata[15:0];
            default: ;
         endcase
      end
   end
   always_comb begin
      case (paddr[3:2])
         fst_pkg::REG_TCP:  prdata = {16'd0, tcp_to_ff};
         fst_pkg::REG_UDP:  prdata = {16'd0, udp_to_ff};
         fst_pkg::REG_ICMP: prdata = {16'd0, icmp_to_ff};
         default:           prdata = 32'd0;
      endcase
   end

   // Memory port
   logic                  mem_we;
   logic [SlotW-1:0]      mem_addr;
   fst_pkg::entry_type    mem_wdata, mem_rdata;
   fst_ram u_ram (.clock(clock), .wr_en(mem_we), .addr(mem_addr),
                  .wr_data(mem_wdata), .rd_data(mem_rdata));

   state_type         state_ff;
   logic [SlotW:0]    idx_ff;       // sweep / clear walker, one spare bit
   logic [fst_pkg::WayW:0] way_ff;
   logic [1:0]        op_ff, bnd_ff;
   logic [31:0]       sa_ff, da_ff, now_ff, fold_ff, next_sweep_ff;
   logic [15:0]       sp_ff, dp_ff;
   logic [7:0]        proto_ff, flags_ff;
   logic [BucketW-1:0] bucket_ff;
   logic              found_ff, rev_ff, free_seen_ff;
   logic [fst_pkg::WayW:0] hit_way_ff, free_way_ff;
   fst_pkg::entry_type hit_ent_ff;
   logic [12:0]       live_ff, tcp_cnt_ff, udp_cnt_ff, icmp_cnt_ff, expired_ff;
   logic [11:0]       slot_ff;
   logic              created_ff, closed_ff, full_ff;

   // Slot address built from bucket and way
   function automatic logic [SlotW-1:0] slot_of(input logic [BucketW-1:0] b,
                                                input logic [fst_pkg::WayW:0] w);
      logic [SlotW:0] s;
      s = {1'b0, b, {fst_pkg::WayFieldW{1'b0}}} + (SlotW + 1)'(w);
      return s[SlotW-1:0];
   endfunction

   // Compare logic for the current read
   logic [9:0]  pb_cur;
   logic        m_fwd, m_rev;
   logic        is_tcp, is_udp, is_icmp;
   logic [3:0]  marks_new;
   logic [32:0] limit;
   logic [7:0]  ent_proto;
   logic        sw_expire;
   assign pb_cur = {proto_ff, bnd_ff};
   assign m_fwd = mem_rdata.valid && mem_rdata.proto_bound == pb_cur &&
                  mem_rdata.src_addr == sa_ff && mem_rdata.dst_addr == da_ff &&
                  mem_rdata.ports == {sp_ff, dp_ff};
   assign m_rev = mem_rdata.valid && mem_rdata.proto_bound == pb_cur &&
                  mem_rdata.src_addr == da_ff && mem_rdata.dst_addr == sa_ff &&
                  mem_rdata.ports == {dp_ff, sp_ff};
   assign ent_proto = mem_rdata.proto_bound[9:2];
   always_comb begin
      case (ent_proto)
         fst_pkg::PROTO_TCP:  limit = {1'b0, mem_rdata.last_seen} + {17'd0, tcp_to_ff};
         fst_pkg::PROTO_UDP:  limit = {1'b0, mem_rdata.last_seen} + {17'd0, udp_to_ff};
         default:             limit = {1'b0, mem_rdata.last_seen} + {17'd0, icmp_to_ff};
      endcase
   end
   assign sw_expire = mem_rdata.valid && (ent_proto == fst_pkg::PROTO_TCP ||
                      ent_proto == fst_pkg::PROTO_UDP || ent_proto == fst_pkg::PROTO_ICMP)
                      && ({1'b0, now_ff} >= limit);
   assign is_tcp = proto_ff == fst_pkg::PROTO_TCP;
   assign is_udp = proto_ff == fst_pkg::PROTO_UDP;
   assign is_icmp = proto_ff == fst_pkg::PROTO_ICMP;

   logic [3:0] marks_base;
   assign marks_base = found_ff ? hit_ent_ff.marks : 4'd0;
   assign marks_new = marks_base | {flags_ff[2], flags_ff[1],
                      flags_ff[0] & rev_ff, flags_ff[0] & ~rev_ff};
   logic do_close;
   assign do_close = is_tcp && (marks_new[3] || (marks_new[0] && marks_new[1]));

   assign busy = state_ff != ST_IDLE;

   // Memory address / write selection
   always_comb begin
      mem_we = 1'b0;
      mem_addr = slot_of(bucket_ff, way_ff);
      mem_wdata = hit_ent_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_addr = idx_ff[SlotW-1:0];
            mem_wdata = '0;
         end
         ST_SWEEP_RD: mem_addr = idx_ff[SlotW-1:0];
         ST_SWEEP_CHK: begin
            mem_addr = idx_ff[SlotW-1:0];
            mem_we = sw_expire;
            mem_wdata = mem_rdata;
            mem_wdata.valid = 1'b0;
         end
         ST_WRITE: begin
            mem_addr = found_ff ? slot_of(bucket_ff, hit_way_ff)
                                : slot_of(bucket_ff, free_way_ff);
            mem_we = 1'b1;
            mem_wdata.valid = ~do_close;
            mem_wdata.src_addr = found_ff ? hit_ent_ff.src_addr : sa_ff;
            mem_wdata.dst_addr = found_ff ? hit_ent_ff.dst_addr : da_ff;
            mem_wdata.ports = found_ff ? hit_ent_ff.ports : {sp_ff, dp_ff};
            mem_wdata.proto_bound = pb_cur;
            mem_wdata.last_seen = now_ff;
            mem_wdata.marks = is_tcp ? marks_new : marks_base;
         end
         default: ;
      endcase
   end

   // Saturating decrement by protocol of a freed session
   function automatic logic [12:0] dec(input logic [12:0] v);
      return (v != 13'd0) ? v - 13'd1 : v;
   endfunction

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (reset) begin
         state_ff <= ST_CLEAR;
         idx_ff <= '0;
         next_sweep_ff <= '0;
         live_ff <= '0;
         tcp_cnt_ff <= '0;
         udp_cnt_ff <= '0;
         icmp_cnt_ff <= '0;
      end else begin
         case (state_ff)
            ST_CLEAR: begin
               // sweep the memory to invalid, one entry a cycle
               idx_ff <= idx_ff + 1'b1;
               if (idx_ff[SlotW-1:0] == SlotW'(fst_pkg::Slots - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  op_ff <= req_operation;
                  sa_ff <= req_src_addr;
                  da_ff <= req_dst_addr;
                  sp_ff <= req_src_port_num;
                  dp_ff <= req_dst_port_num;
                  proto_ff <= req_proto;
                  bnd_ff <= (req_operation == fst_pkg::OP_SEARCH) ? 2'd0 : req_bound_kind;
                  flags_ff <= req_tcp_flags;
                  now_ff <= req_now_seconds;
                  expired_ff <= '0;
                  created_ff <= 1'b0;
                  closed_ff <= 1'b0;
                  full_ff <= 1'b0;
                  found_ff <= 1'b0;
                  rev_ff <= 1'b0;
                  slot_ff <= '0;
                  idx_ff <= '0;
                  if (req_operation == fst_pkg::OP_GET &&
                      req_now_seconds >= next_sweep_ff) begin
                     next_sweep_ff <= req_now_seconds + 32'd1;
                     state_ff <= ST_SWEEP_RD;
                  end else if (req_operation == fst_pkg::OP_GET ||
                               req_operation == fst_pkg::OP_FIND ||
                               req_operation == fst_pkg::OP_SEARCH) begin
                     state_ff <= ST_HASH;
                  end else begin
                     state_ff <= ST_DONE;
                  end
               end
            end
            ST_SWEEP_RD: state_ff <= ST_SWEEP_CHK;
            ST_SWEEP_CHK: begin
               // drop entries idle past their timeout
               if (sw_expire) begin
                  expired_ff <= expired_ff + 13'd1;
                  live_ff <= dec(live_ff);
                  if (ent_proto == fst_pkg::PROTO_TCP) tcp_cnt_ff <= dec(tcp_cnt_ff);
                  if (ent_proto == fst_pkg::PROTO_UDP) udp_cnt_ff <= dec(udp_cnt_ff);
                  if (ent_proto == fst_pkg::PROTO_ICMP) icmp_cnt_ff <= dec(icmp_cnt_ff);
               end
               idx_ff <= idx_ff + 1'b1;
               state_ff <= (idx_ff[SlotW-1:0] == SlotW'(fst_pkg::Slots - 1))
                           ? ST_HASH : ST_SWEEP_RD;
            end
            ST_HASH: begin
               fold_ff <= fst_pkg::hash_fold(da_ff, dp_ff, sa_ff, sp_ff, proto_ff, bnd_ff);
               way_ff <= '0;
               free_seen_ff <= 1'b0;
               state_ff <= ST_MIX;
            end
            ST_MIX: begin
               bucket_ff <= fst_pkg::hash_mix(fold_ff);
               state_ff <= ST_RD;
            end
            ST_RD: state_ff <= ST_CMP;
            ST_CMP: begin
               // first matching way wins; track the lowest free way
               if (!mem_rdata.valid && !free_seen_ff) begin
                  free_seen_ff <= 1'b1;
                  free_way_ff <= way_ff;
               end
               if (m_fwd || m_rev) begin
                  found_ff <= 1'b1;
                  rev_ff <= ~m_fwd;
                  hit_way_ff <= way_ff;
                  hit_ent_ff <= mem_rdata;
                  state_ff <= ST_DECIDE;
               end else if (way_ff == (fst_pkg::WayW + 1)'(fst_pkg::Ways - 1)) begin
                  state_ff <= ST_DECIDE;
               end else begin
                  way_ff <= way_ff + 1'b1;
                  state_ff <= ST_RD;
               end
            end
            ST_DECIDE: begin
               if (found_ff) begin
                  slot_ff <= 12'(slot_of(bucket_ff, hit_way_ff));
                  state_ff <= (op_ff == fst_pkg::OP_SEARCH) ? ST_DONE : ST_WRITE;
               end else if (op_ff == fst_pkg::OP_SEARCH && bnd_ff != 2'd2) begin
                  bnd_ff <= bnd_ff + 2'd1;
                  state_ff <= ST_HASH;
               end else if (op_ff == fst_pkg::OP_GET && free_seen_ff) begin
                  slot_ff <= 12'(slot_of(bucket_ff, free_way_ff));
                  created_ff <= 1'b1;
                  live_ff <= live_ff + 13'd1;
                  if (is_tcp) tcp_cnt_ff <= tcp_cnt_ff + 13'd1;
                  if (is_udp) udp_cnt_ff <= udp_cnt_ff + 13'd1;
                  if (is_icmp) icmp_cnt_ff <= icmp_cnt_ff + 13'd1;
                  state_ff <= ST_WRITE;
               end else begin
                  full_ff <= op_ff == fst_pkg::OP_GET;
                  state_ff <= ST_DONE;
               end
            end
            ST_WRITE: begin
               // write back refreshed entry; release it on close
               if (do_close) begin
                  closed_ff <= 1'b1;
                  live_ff <= dec(live_ff);
                  if (is_tcp) tcp_cnt_ff <= dec(tcp_cnt_ff);
               end
               state_ff <= ST_DONE;
            end
            ST_DONE: begin
               rsp_valid <= 1'b1;
               rsp_hit <= found_ff;
               rsp_created <= created_ff;
               rsp_from_destination <= found_ff & rev_ff;
               rsp_session_slot <= slot_ff;
               rsp_closed <= closed_ff;
               rsp_table_full <= full_ff;
               rsp_expired_count <= expired_ff;
               rsp_active_sessions <= live_ff;
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire

[src/fst_ram.sv]
// ----------------------------------------------------------------------------
// fst_ram
// Single-port synchronous session memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module fst_ram (
   input  wire logic                       clock,
   input  wire logic                       wr_en,
   input  wire logic [fst_pkg::SlotW-1:0]  addr,
   input  fst_pkg::entry_type              wr_data,
   output fst_pkg::entry_type              rd_data
);
   fst_pkg::entry_type mem [fst_pkg::Slots];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule
`default_nettype wire
